>>> rtl/slot_handle_allocator_defines.svh
// assertion macros used by the slot handle allocator datapath
`ifndef SLOT_HANDLE_ALLOCATOR_DEFINES_SVH
`define SLOT_HANDLE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication, disabled during reset
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> rtl/sha_pkg.sv
// types and constants shared by the slot handle allocator modules
package sha_pkg;

   localparam int CMD_W    = 3;
   localparam int ID_W     = 9;
   localparam int STATUS_W = 2;
   localparam int TALLY_W  = 10;

   localparam logic [TALLY_W-1:0] TALLY_MAX = 10'd1023;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FREE    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MARK    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PROCESS = 3'd4;
   localparam logic [CMD_W-1:0] CMD_COUNT   = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STS_NOT_VALID = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;    // latch the request and issue memory reads
      logic execute;    // perform the command and load the result register
      logic walk_step;  // advance the process-pending sweep
   } sha_ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;   // result register can take a new result this cycle
      logic walk_done;  // sweep has visited every used slot
   } sha_sts_type;

endpackage

>>> rtl/slot_handle_allocator.sv
// top level of the slot handle allocator: controller plus datapath
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  req_command, req_slot_id
//   rsp_      out        rsp_valid / rsp_ready  rsp_status, rsp_granted_slot,
//                                               rsp_is_valid, rsp_tally
//
// allocate, free, check, mark dirty, count and unused codes go through two steps:
//   accept (memory reads issued) then execute (memory write, result loaded)
// process pending sweeps the used slots, used being the slots ever
//   handed out; the sweep reads one slot per cycle through the slot state port
// a new transaction is taken only once the previous one has executed; the
//   result register holds a finished result while the next one is accepted
// after reset the block is ready at once: slots above the fresh mark read as
//   free, so the slot state memory needs no clearing pass
// a stalled result channel holds the execute step until the result register frees
module slot_handle_allocator #(
   parameter int SLOTS = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [sha_pkg::CMD_W-1:0]    req_command,
   input  logic [sha_pkg::ID_W-1:0]     req_slot_id,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sha_pkg::STATUS_W-1:0] rsp_status,
   output logic [sha_pkg::ID_W-1:0]     rsp_granted_slot,
   output logic                         rsp_is_valid,
   output logic [sha_pkg::TALLY_W-1:0]  rsp_tally
);
   import sha_pkg::*;

   // command and status between controller and datapath
   sha_ctl_type ctl;
   sha_sts_type sts;

   // sequencing: accept, optional sweep, execute
   sha_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .sts         (sts),
      .ctl         (ctl)
   );

   // slot state memory, free stack, counters and result register
   sha_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .req_command      (req_command),
      .req_slot_id      (req_slot_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_is_valid     (rsp_is_valid),
      .rsp_tally        (rsp_tally)
   );

endmodule

>>> rtl/sha_ctrl.sv
// controller state machine for the slot handle allocator
module sha_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [sha_pkg::CMD_W-1:0] req_command,
   input  sha_pkg::sha_sts_type      sts,
   output sha_pkg::sha_ctl_type      ctl
);
   import sha_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      accept;

   assign req_ready = ready_ff;
   assign accept    = req_valid && ready_ff;

   always_comb begin
      state_in      = state_ff;
      ready_in      = ready_ff;
      ctl.capture   = 1'b0;
      ctl.execute   = 1'b0;
      ctl.walk_step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctl.capture = 1'b1;
               ready_in    = 1'b0;
               state_in    = (req_command == CMD_PROCESS) ? ST_WALK : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.out_free) begin
               ctl.execute = 1'b1;
               ready_in    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (sts.walk_done) begin
               state_in = ST_EXEC;
            end else begin
               ctl.walk_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

endmodule

>>> rtl/sha_datapath.sv
// datapath of the slot handle allocator: slot state, free stack, counters, result
module sha_datapath #(
   parameter int SLOTS = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sha_pkg::sha_ctl_type         ctl,
   output sha_pkg::sha_sts_type         sts,
   input  logic [sha_pkg::CMD_W-1:0]    req_command,
   input  logic [sha_pkg::ID_W-1:0]     req_slot_id,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sha_pkg::STATUS_W-1:0] rsp_status,
   output logic [sha_pkg::ID_W-1:0]     rsp_granted_slot,
   output logic                         rsp_is_valid,
   output logic [sha_pkg::TALLY_W-1:0]  rsp_tally
);
   import sha_pkg::*;
   `include "slot_handle_allocator_defines.svh"

   localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW   = $clog2(SLOTS + 1);
   localparam int CMPW = (CW > ID_W) ? CW : ID_W;
   localparam int TW   = (CW > TALLY_W) ? CW : TALLY_W;

   // slot state memory: bit 1 valid, bit 0 dirty; entries at or above the
   // fresh mark were never written and read as free
   logic [1:0]    slot_mem [SLOTS];
   logic [SW-1:0] stack_mem [SLOTS];

   logic [1:0]    slot_rd_ff;
   logic [SW-1:0] stack_rd_ff;

   logic          mem_re, mem_we, stk_re, stk_we;
   logic [SW-1:0] mem_raddr, mem_waddr, stk_raddr, stk_waddr, stk_wdata;
   logic [1:0]    mem_wdata;

   logic [CW-1:0] free_top_ff, free_top_in;
   logic [CW-1:0] next_fresh_ff, next_fresh_in;
   logic [CW-1:0] active_ff, active_in;
   logic [CW-1:0] walk_ff, walk_in;
   logic [CW-1:0] dcount_ff, dcount_in;
   logic          pend_ff, pend_in;
   logic [SW-1:0] paddr_ff, paddr_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [ID_W-1:0]  id_ff, id_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]     granted_ff, granted_in;
   logic                is_valid_ff, is_valid_in;
   logic [TALLY_W-1:0]  tally_ff, tally_in;

   logic          in_range, live, have_stack, got;
   logic [SW-1:0] alloc_slot, id_idx;
   logic [CW-1:0] top_dec;

   function automatic logic [TALLY_W-1:0] sat_tally(input logic [CW-1:0] v);
      logic [TW-1:0] w;
      w = TW'(v);
      return (w > TW'(TALLY_MAX)) ? TALLY_MAX : TALLY_W'(w);
   endfunction

   assign in_range   = CMPW'(id_ff) < CMPW'(next_fresh_ff);
   assign live       = in_range && slot_rd_ff[1];
   assign id_idx     = SW'(id_ff);
   assign have_stack = (free_top_ff != '0);
   assign got        = have_stack || (next_fresh_ff != CW'(SLOTS));
   assign alloc_slot = have_stack ? stack_rd_ff : next_fresh_ff[SW-1:0];
   assign top_dec    = free_top_ff - CW'(1);

   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign sts.walk_done = (walk_ff == next_fresh_ff) && !pend_ff;

   always_comb begin
      free_top_in   = free_top_ff;
      next_fresh_in = next_fresh_ff;
      active_in     = active_ff;
      walk_in       = walk_ff;
      dcount_in     = dcount_ff;
      pend_in       = pend_ff;
      paddr_in      = paddr_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      mem_re        = 1'b0;
      mem_raddr     = walk_ff[SW-1:0];
      mem_we        = 1'b0;
      mem_waddr     = id_idx;
      mem_wdata     = 2'b11;
      stk_re        = 1'b0;
      stk_raddr     = top_dec[SW-1:0];
      stk_we        = 1'b0;
      stk_waddr     = free_top_ff[SW-1:0];
      stk_wdata     = id_idx;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      status_in     = status_ff;
      granted_in    = granted_ff;
      is_valid_in   = is_valid_ff;
      tally_in      = tally_ff;

      if (ctl.capture) begin
         cmd_in    = req_command;
         id_in     = req_slot_id;
         walk_in   = '0;
         dcount_in = '0;
         pend_in   = 1'b0;
         mem_re    = 1'b1;
         mem_raddr = SW'(req_slot_id);
         stk_re    = 1'b1;
      end

      if (ctl.walk_step) begin
         pend_in = 1'b0;
         if (walk_ff != next_fresh_ff) begin
            mem_re    = 1'b1;
            mem_raddr = walk_ff[SW-1:0];
            paddr_in  = walk_ff[SW-1:0];
            pend_in   = 1'b1;
            walk_in   = walk_ff + CW'(1);
         end
         if (pend_ff && slot_rd_ff[1] && slot_rd_ff[0]) begin
            mem_we    = 1'b1;
            mem_waddr = paddr_ff;
            mem_wdata = 2'b10;
            dcount_in = dcount_ff + CW'(1);
         end
      end

      if (ctl.execute) begin
         rsp_valid_in = 1'b1;
         status_in    = STS_OK;
         granted_in   = '0;
         is_valid_in  = 1'b0;
         tally_in     = '0;
         case (cmd_ff)
            CMD_ALLOC: begin
               if (got) begin
                  mem_we      = 1'b1;
                  mem_waddr   = alloc_slot;
                  mem_wdata   = 2'b11;
                  active_in   = active_ff + CW'(1);
                  granted_in  = ID_W'(alloc_slot);
                  is_valid_in = 1'b1;
                  if (have_stack) begin
                     free_top_in = top_dec;
                  end else begin
                     next_fresh_in = next_fresh_ff + CW'(1);
                  end
               end else begin
                  status_in = STS_FULL;
               end
            end
            CMD_FREE: begin
               if (live) begin
                  mem_we      = 1'b1;
                  mem_wdata   = {1'b0, slot_rd_ff[0]};
                  stk_we      = 1'b1;
                  free_top_in = free_top_ff + CW'(1);
                  active_in   = active_ff - CW'(1);
               end else begin
                  status_in = STS_NOT_VALID;
               end
            end
            CMD_CHECK: begin
               if (live) begin
                  is_valid_in = 1'b1;
               end else begin
                  status_in = STS_NOT_VALID;
               end
            end
            CMD_MARK: begin
               if (live) begin
                  mem_we      = 1'b1;
                  mem_wdata   = 2'b11;
                  is_valid_in = 1'b1;
               end else begin
                  status_in = STS_NOT_VALID;
               end
            end
            CMD_PROCESS: begin
               tally_in = sat_tally(dcount_ff);
            end
            CMD_COUNT: begin
               tally_in = sat_tally(active_ff);
            end
            default: begin
               status_in = STS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         slot_rd_ff <= slot_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stack_rd_ff <= stack_mem[stk_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_top_ff   <= '0;
         next_fresh_ff <= '0;
         active_ff     <= '0;
         walk_ff       <= '0;
         dcount_ff     <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_top_ff   <= free_top_in;
         next_fresh_ff <= next_fresh_in;
         active_ff     <= active_in;
         walk_ff       <= walk_in;
         dcount_ff     <= dcount_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      paddr_ff    <= paddr_in;
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      status_ff   <= status_in;
      granted_ff  <= granted_in;
      is_valid_ff <= is_valid_in;
      tally_ff    <= tally_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_granted_slot = granted_ff;
   assign rsp_is_valid     = is_valid_ff;
   assign rsp_tally        = tally_ff;

   // every used slot is either live or parked on the free stack
   `SHA_ASSERT_IMPL(a_slot_balance, clock, reset, 1'b1, ((CW+1)'(free_top_ff) + (CW+1)'(active_ff)) == (CW+1)'(next_fresh_ff))
   // a result is only loaded when the result register can take it
   `SHA_ASSERT_IMPL(a_exec_out_free, clock, reset, ctl.execute, sts.out_free)
   // sweep writes and command writes never share the write port
   `SHA_ASSERT_IMPL(a_one_writer, clock, reset, ctl.walk_step, !ctl.execute && !ctl.capture)
   // sweep cursor never passes the fresh mark
   `SHA_ASSERT_NEXT(a_walk_bound, clock, reset, ctl.walk_step, walk_ff <= next_fresh_ff)

endmodule

>>> sim/tb.sv
// self-checking testbench for the slot handle allocator
`timescale 1ns / 100ps

module tb;
   import sha_pkg::*;

   localparam int SLOTS         = 512;
   localparam int RANDOM_ITEMS  = 930;   // counted commands in the random part
   localparam int CALM_ITEMS    = 100;   // closing stretch with no idling
   localparam int HOLD_CYCLES   = 200;   // long result-side hold-off
   localparam int QUIET_LIMIT   = 5000;  // watchdog: cycles with no transaction
   localparam int DRAIN_CYCLES  = 40;

   // command codes the block must ignore
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

   // shape of the random stimulus
   typedef enum int {MIX_PHASE, FILL_PHASE, DRAIN_PHASE} stim_phase_type;

   // one reply of the block, field by field
   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     granted;
      logic                is_valid;
      logic [TALLY_W-1:0]  tally;
   } reply_type;

   // slot pool shadow plus the replies still owed by the block
   class alloc_scoreboard_type;
      bit              live  [SLOTS];
      bit              dirty [SLOTS];
      logic [ID_W-1:0] stack [SLOTS];
      int unsigned     top;
      int unsigned     fresh;
      int unsigned     active;
      reply_type       expected_replies[$];
      int              errors;
      int              n_grants, n_full, n_rejects, n_sweeps, n_replies;

      function new();
         top    = 0;
         fresh  = 0;
         active = 0;
         errors = 0;
         n_grants = 0; n_full = 0; n_rejects = 0; n_sweeps = 0; n_replies = 0;
         foreach (live[i]) begin
            live[i]  = 1'b0;
            dirty[i] = 1'b0;
            stack[i] = '0;
         end
      endfunction

      function bit pool_full();
         return (top == 0) && (fresh >= SLOTS);
      endfunction

      // a random allocated handle, or a random one if none is allocated
      function logic [ID_W-1:0] live_handle();
         int start;
         int k;
         int idx;
         start = $urandom_range(0, SLOTS - 1);
         for (k = 0; k < SLOTS; k++) begin
            idx = (start + k) % SLOTS;
            if (live[idx]) return idx[ID_W-1:0];
         end
         return start[ID_W-1:0];
      endfunction

      // executes one command on the shadow pool and returns its reply
      function reply_type apply_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
         reply_type   r;
         int unsigned n;
         logic [ID_W-1:0] slot;
         bit          got;
         r.status   = STS_OK;
         r.granted  = '0;
         r.is_valid = 1'b0;
         r.tally    = '0;
         n   = 0;
         got = 1'b0;
         slot = '0;
         case (cmd)
            CMD_ALLOC: begin
               // lifo reuse first, then the fresh mark
               if (top > 0) begin
                  top--;
                  slot = stack[top];
                  got  = 1'b1;
               end else if (fresh < SLOTS) begin
                  slot = fresh[ID_W-1:0];
                  fresh++;
                  got  = 1'b1;
               end
               if (got) begin
                  live[slot]  = 1'b1;
                  dirty[slot] = 1'b1;
                  active++;
                  r.granted  = slot;
                  r.is_valid = 1'b1;
               end else begin
                  r.status = STS_FULL;
               end
            end
            CMD_FREE: begin
               if (live[id]) begin
                  live[id] = 1'b0;   // dirty bit left alone
                  active--;
                  if (top < SLOTS) begin
                     stack[top] = id;
                     top++;
                  end
               end else begin
                  r.status = STS_NOT_VALID;
               end
            end
            CMD_CHECK: begin
               if (live[id]) r.is_valid = 1'b1;
               else r.status = STS_NOT_VALID;
            end
            CMD_MARK: begin
               if (live[id]) begin
                  dirty[id]  = 1'b1;
                  r.is_valid = 1'b1;
               end else begin
                  r.status = STS_NOT_VALID;
               end
            end
            CMD_PROCESS: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (live[i] && dirty[i]) begin
                     dirty[i] = 1'b0;
                     n++;
                  end
               end
               r.tally = (n > TALLY_MAX) ? TALLY_MAX : TALLY_W'(n);
            end
            CMD_COUNT: begin
               for (int i = 0; i < SLOTS; i++) if (live[i]) n++;
               r.tally = (n > TALLY_MAX) ? TALLY_MAX : TALLY_W'(n);
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
         reply_type r;
         r = apply_command(cmd, id);
         if (cmd == CMD_ALLOC && r.status == STS_OK) n_grants++;
         if (r.status == STS_FULL) n_full++;
         if (r.status == STS_NOT_VALID) n_rejects++;
         if (cmd == CMD_PROCESS) n_sweeps++;
         expected_replies.push_back(r);
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_reply(logic [STATUS_W-1:0] status, logic [ID_W-1:0] granted,
                       logic is_valid, logic [TALLY_W-1:0] tally);
         reply_type want;
         n_replies++;
         if (expected_replies.size() == 0) begin
            report($sformatf("reply with nothing outstanding (status %0d slot %0d)",
                             status, granted));
            return;
         end
         want = expected_replies.pop_front();
         if (status !== want.status)
            report($sformatf("status %0d, want %0d", status, want.status));
         if (granted !== want.granted)
            report($sformatf("granted_slot %0d, want %0d", granted, want.granted));
         if (is_valid !== want.is_valid)
            report($sformatf("is_valid %0d, want %0d", is_valid, want.is_valid));
         if (tally !== want.tally)
            report($sformatf("tally %0d, want %0d", tally, want.tally));
      endtask
   endclass

   // clock, reset and block ports, all known from time zero
   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command      = CMD_COUNT;
   logic [ID_W-1:0]     req_slot_id      = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_granted_slot;
   logic                rsp_is_valid;
   logic [TALLY_W-1:0]  rsp_tally;

   alloc_scoreboard_type sb = new();

   int counted_items = 0;   // commands 0 to 5 sent in the random part
   int accepted_reqs = 0;
   bit calm          = 1'b0; // closing stretch: no idling on either side
   bit held          = 1'b0; // long hold-off already done

   always #1 clock = ~clock;

   slot_handle_allocator #(.SLOTS(SLOTS)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_slot_id      (req_slot_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_is_valid     (rsp_is_valid),
      .rsp_tally        (rsp_tally)
   );

   // sends one request transaction; an idle burst may come first
   // the shadow pool is updated at the accepting edge, so the next pick sees it
   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_slot_id <= id;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, id);
      accepted_reqs++;
   endtask

   // picks one random command shaped by the current phase
   task automatic random_item(input stim_phase_type ph);
      int              r;
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0]  id;
      r  = $urandom_range(0, 99);
      id = ID_W'($urandom_range(0, SLOTS - 1));
      cmd = CMD_ALLOC;
      if (ph == FILL_PHASE && sb.pool_full()) begin
         // pool exhausted: keep asking for more, and look at the count
         if (r < 50) cmd = CMD_ALLOC;
         else if (r < 70) cmd = CMD_COUNT;
         else if (r < 80) cmd = CMD_PROCESS;
         else if (r < 90) begin cmd = CMD_CHECK; id = sb.live_handle(); end
         else cmd = CMD_CHECK;
      end else if (ph == FILL_PHASE) begin
         if (r < 85) cmd = CMD_ALLOC;
         else if (r < 89) begin cmd = CMD_FREE; id = sb.live_handle(); end
         else if (r < 93) cmd = CMD_CHECK;
         else if (r < 96) begin cmd = CMD_MARK; id = sb.live_handle(); end
         else if (r < 97) cmd = CMD_PROCESS;
         else if (r < 99) cmd = CMD_COUNT;
         else cmd = CMD_W'($urandom_range(0, 7));
      end else if (ph == DRAIN_PHASE) begin
         if (r < 70) begin cmd = CMD_FREE; id = sb.live_handle(); end
         else if (r < 78) cmd = CMD_ALLOC;
         else if (r < 85) cmd = CMD_CHECK;
         else if (r < 90) begin cmd = CMD_MARK; id = sb.live_handle(); end
         else if (r < 93) cmd = CMD_PROCESS;
         else if (r < 97) cmd = CMD_COUNT;
         else cmd = CMD_W'($urandom_range(0, 7));
      end else begin
         if (r < 30) cmd = CMD_ALLOC;
         else if (r < 55) begin
            cmd = CMD_FREE;
            if ($urandom_range(0, 4) != 0) id = sb.live_handle();
         end else if (r < 70) begin
            cmd = CMD_CHECK;
            if ($urandom_range(0, 1) != 0) id = sb.live_handle();
         end else if (r < 82) begin
            cmd = CMD_MARK;
            if ($urandom_range(0, 2) != 0) id = sb.live_handle();
         end else if (r < 88) cmd = CMD_PROCESS;
         else if (r < 94) cmd = CMD_COUNT;
         else cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
      end
      issue(cmd, id);
      if (cmd <= CMD_COUNT) counted_items++;
   endtask

   // result side: random stall bursts, open stretches, one long hold-off
   initial begin
      int n;
      wait (reset == 1'b0);
      forever begin
         if (!calm && !held && accepted_reqs >= 250) begin
            // block backs up and stalls its input while the sender keeps offering
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 40);
            rsp_ready <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   // result transactions go straight to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_reply(rsp_status, rsp_granted_slot, rsp_is_valid, rsp_tally);
   end

   // watchdog on stretches with no transaction on either channel
   initial begin
      int quiet;
      quiet = 0;
      wait (reset == 1'b0);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no transaction for %0d cycles, %0d replies outstanding",
               QUIET_LIMIT, sb.expected_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // main sequence
   initial begin
      stim_phase_type ph;
      int             seg_left;
      bit             full_hit;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pool, rejected handles, fresh grants, lifo reuse,
      // dirty sweep, freed slot keeps its dirty bit out of the sweep, spare codes
      issue(CMD_COUNT,   9'd0);
      issue(CMD_PROCESS, 9'd0);
      issue(CMD_CHECK,   9'd0);
      issue(CMD_FREE,    9'd511);
      issue(CMD_MARK,    9'd0);
      issue(CMD_ALLOC,   9'd0);
      issue(CMD_ALLOC,   9'd0);
      issue(CMD_ALLOC,   9'd511);
      issue(CMD_MARK,    9'd1);
      issue(CMD_CHECK,   9'd2);
      issue(CMD_PROCESS, 9'd0);
      issue(CMD_PROCESS, 9'd0);
      issue(CMD_FREE,    9'd1);
      issue(CMD_FREE,    9'd1);
      issue(CMD_CHECK,   9'd1);
      issue(CMD_ALLOC,   9'd0);
      issue(CMD_FREE,    9'd0);
      issue(CMD_FREE,    9'd2);
      issue(CMD_ALLOC,   9'd0);
      issue(CMD_ALLOC,   9'd0);
      issue(CMD_MARK,    9'd2);
      issue(CMD_FREE,    9'd2);
      issue(CMD_PROCESS, 9'd0);
      issue(CMD_SPARE_A, 9'd511);
      issue(CMD_SPARE_B, 9'd0);

      // random: mixed traffic, fill to exhaustion, drain, and around again
      ph       = MIX_PHASE;
      seg_left = $urandom_range(60, 120);
      full_hit = 1'b0;
      while (counted_items < RANDOM_ITEMS) begin
         if (counted_items >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         if (ph == FILL_PHASE && !full_hit && sb.pool_full()) begin
            full_hit = 1'b1;
            seg_left = 15;
         end
         if (ph == DRAIN_PHASE && sb.active <= 40) seg_left = 0;
         if (seg_left <= 0) begin
            case (ph)
               MIX_PHASE: begin
                  ph       = FILL_PHASE;
                  seg_left = 1000000;   // ends 15 items after the pool runs out
                  full_hit = 1'b0;
               end
               FILL_PHASE: begin
                  ph       = DRAIN_PHASE;
                  seg_left = 250;
               end
               default: begin
                  ph       = MIX_PHASE;
                  seg_left = $urandom_range(60, 120);
               end
            endcase
         end
         random_item(ph);
         seg_left--;
      end
      req_valid <= 1'b0;

      while (sb.expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d grants, %0d pool-full answers, %0d rejected handles",
               accepted_reqs, sb.n_grants, sb.n_full, sb.n_rejects);
      $display("%0d pending sweeps, %0d replies checked, %0d mismatches",
               sb.n_sweeps, sb.n_replies, sb.errors);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
